// ----- sv/tccw_pkg.sv -----
// Package for the text console cell writer: payload structs, sequencer steps,
// control word layout and the microcode table.
// No dependencies; every module of the block imports it.
package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam logic [15:0] BLANK_CELL   = 16'h0F20;
    localparam logic [7:0]  NEWLINE_CODE = 8'd10;
    localparam logic [7:0]  SPACE_CODE   = 8'h20;
    localparam logic [7:0]  COLOR_RESET  = 8'd15;

    localparam logic [1:0] ACT_PRINT = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;

    typedef struct packed {
        logic [1:0] action;
        logic [7:0] char_code;
        logic [6:0] read_col;
        logic [4:0] read_row;
    } in_item_t;

    typedef struct packed {
        logic [15:0] cell_data;
        logic [4:0]  cursor_row;
        logic [6:0]  cursor_col;
        logic        scrolled;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PUT,
        ST_LF,
        ST_SCR_RD,
        ST_SCR_WR,
        ST_FILL,
        ST_CLR,
        ST_RD,
        ST_DONE,
        ST_INIT
    } step_t;

    typedef enum logic [1:0] {WS_CHAR, WS_BLANK, WS_SPACE, WS_COPY} wsrc_t;
    typedef enum logic [1:0] {RS_NONE, RS_NEXT_ROW, RS_CELL} rsrc_t;
    typedef enum logic [1:0] {PTR_HOLD, PTR_CLEAR, PTR_INC} ptr_op_t;
    typedef enum logic [1:0] {CUR_HOLD, CUR_ADV, CUR_LF, CUR_HOME} cur_op_t;
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_COL_LAST,
        C_ROW_LAST,
        C_MOVE_END,
        C_GRID_END
    } cond_t;

    typedef struct packed {
        logic    mem_we;
        logic    waddr_cursor;
        wsrc_t   wsrc;
        rsrc_t   rsrc;
        ptr_op_t ptr_op;
        cur_op_t cur_op;
        logic    set_scroll;
        logic    respond;
        cond_t   cond;
        step_t   tgt_t;
        step_t   tgt_f;
    } ctl_word_t;

    function automatic ctl_word_t ucode(input step_t s);
        ctl_word_t w;
        w.mem_we       = 1'b0;
        w.waddr_cursor = 1'b0;
        w.wsrc         = WS_BLANK;
        w.rsrc         = RS_NONE;
        w.ptr_op       = PTR_HOLD;
        w.cur_op       = CUR_HOLD;
        w.set_scroll   = 1'b0;
        w.respond      = 1'b0;
        w.cond         = C_ALWAYS;
        w.tgt_t        = ST_IDLE;
        w.tgt_f        = ST_IDLE;
        case (s)
            ST_IDLE:
            begin
                w.ptr_op = PTR_CLEAR;
                w.cond   = C_DISPATCH;
            end
            ST_PUT:
            begin
                w.mem_we       = 1'b1;
                w.waddr_cursor = 1'b1;
                w.wsrc         = WS_CHAR;
                w.cur_op       = CUR_ADV;
                w.cond         = C_COL_LAST;
                w.tgt_t        = ST_LF;
                w.tgt_f        = ST_DONE;
            end
            ST_LF:
            begin
                w.ptr_op = PTR_CLEAR;
                w.cur_op = CUR_LF;
                w.cond   = C_ROW_LAST;
                w.tgt_t  = ST_SCR_RD;
                w.tgt_f  = ST_DONE;
            end
            ST_SCR_RD:
            begin
                w.rsrc       = RS_NEXT_ROW;
                w.set_scroll = 1'b1;
                w.tgt_t      = ST_SCR_WR;
            end
            ST_SCR_WR:
            begin
                w.mem_we = 1'b1;
                w.wsrc   = WS_COPY;
                w.ptr_op = PTR_INC;
                w.cond   = C_MOVE_END;
                w.tgt_t  = ST_FILL;
                w.tgt_f  = ST_SCR_RD;
            end
            ST_FILL:
            begin
                w.mem_we = 1'b1;
                w.wsrc   = WS_SPACE;
                w.ptr_op = PTR_INC;
                w.cond   = C_GRID_END;
                w.tgt_t  = ST_DONE;
                w.tgt_f  = ST_FILL;
            end
            ST_CLR:
            begin
                w.mem_we = 1'b1;
                w.wsrc   = WS_BLANK;
                w.ptr_op = PTR_INC;
                w.cur_op = CUR_HOME;
                w.cond   = C_GRID_END;
                w.tgt_t  = ST_DONE;
                w.tgt_f  = ST_CLR;
            end
            ST_RD:
            begin
                w.rsrc  = RS_CELL;
                w.tgt_t = ST_DONE;
            end
            ST_DONE:
            begin
                w.respond = 1'b1;
                w.tgt_t   = ST_IDLE;
            end
            ST_INIT:
            begin
                w.mem_we = 1'b1;
                w.wsrc   = WS_BLANK;
                w.ptr_op = PTR_INC;
                w.cond   = C_GRID_END;
                w.tgt_t  = ST_IDLE;
                w.tgt_f  = ST_INIT;
            end
            default:
            begin
                w.tgt_t = ST_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- sv/text_console_cell_writer_top.sv -----
// Text console cell writer: cell grid memory, cursor and a microcoded
// sequencer that steps through the table in tccw_pkg. Depends on tccw_pkg.
//
// Channel  Direction  Handshake               Payload
// command  in         start && !busy          cmd (tccw_pkg::in_item_t)
// result   out        done, one cycle         result (tccw_pkg::out_item_t)
// config   in         cfg_we                  cfg_wdata (color byte)
//
// A print writes in ST_PUT and a read fetches in ST_RD before ST_DONE gives the
// result beat; a line wrap passes ST_LF as well. A scroll adds the row copy
// through the memory, read and write in turn, and a clear writes every cell.
// After reset the grid is blanked with busy high.
// The receiver cannot stall; the result beat is shown for one cycle only.
module text_console_cell_writer_top #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  tccw_pkg::in_item_t  cmd,
    output logic                done,
    output tccw_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata
);
    import tccw_pkg::*;

    localparam int CELLS  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(CELLS);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    logic [15:0] mem [CELLS];
    logic [15:0] rdata_reg;

    step_t              step_reg, step_next;
    logic [ADDR_W-1:0]  ptr_reg, ptr_next;
    logic [COL_W-1:0]   col_reg, col_next;
    logic [ROW_W-1:0]   row_reg, row_next;
    logic               scroll_reg, scroll_next;
    logic               rd_flag_reg, rd_flag_next;
    logic [7:0]         color_reg;
    in_item_t           in_reg;

    ctl_word_t          cw;
    logic               accept;
    logic               cond_hit;
    logic               col_last;
    logic               row_last;
    logic               cmd_in_range;
    logic [ADDR_W-1:0]  cur_addr;
    logic [ADDR_W-1:0]  cell_addr;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic [15:0]        wdata;

    assign cw       = ucode(step_reg);
    assign busy     = (step_reg != ST_IDLE);
    assign accept   = start && !busy;
    assign col_last = (col_reg == COL_W'(COLUMNS - 1));
    assign row_last = (row_reg == ROW_W'(ROWS - 1));

    assign cmd_in_range = ({1'b0, cmd.read_col} < 8'(COLUMNS))
                       && ({2'b00, cmd.read_row} < 7'(ROWS));

    assign cur_addr  = ADDR_W'(row_reg) * ADDR_W'(COLUMNS) + ADDR_W'(col_reg);
    assign cell_addr = ADDR_W'(in_reg.read_row) * ADDR_W'(COLUMNS)
                     + ADDR_W'(in_reg.read_col);

    assign waddr = cw.waddr_cursor ? cur_addr : ptr_reg;
    assign raddr = (cw.rsrc == RS_CELL) ? cell_addr : (ptr_reg + ADDR_W'(COLUMNS));

    always_comb
    begin
        case (cw.wsrc)
            WS_CHAR:  wdata = {color_reg, in_reg.char_code};
            WS_BLANK: wdata = BLANK_CELL;
            WS_SPACE: wdata = {color_reg, SPACE_CODE};
            WS_COPY:  wdata = rdata_reg;
            default:  wdata = BLANK_CELL;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cw.mem_we)
        begin
            mem[waddr] <= wdata;
        end
        if (cw.rsrc != RS_NONE)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    always_comb
    begin
        case (cw.cond)
            C_ALWAYS:   cond_hit = 1'b1;
            C_COL_LAST: cond_hit = col_last;
            C_ROW_LAST: cond_hit = row_last;
            C_MOVE_END: cond_hit = (ptr_reg == ADDR_W'(CELLS - COLUMNS - 1));
            C_GRID_END: cond_hit = (ptr_reg == ADDR_W'(CELLS - 1));
            default:    cond_hit = 1'b0;
        endcase

        if (cw.cond == C_DISPATCH)
        begin
            if (!start)
            begin
                step_next = ST_IDLE;
            end
            else
            begin
                case (cmd.action)
                    ACT_PRINT: step_next = (cmd.char_code == NEWLINE_CODE) ? ST_LF : ST_PUT;
                    ACT_CLEAR: step_next = ST_CLR;
                    ACT_READ:  step_next = ST_RD;
                    default:   step_next = ST_DONE;
                endcase
            end
        end
        else
        begin
            step_next = cond_hit ? cw.tgt_t : cw.tgt_f;
        end

        case (cw.ptr_op)
            PTR_CLEAR: ptr_next = '0;
            PTR_INC:   ptr_next = ptr_reg + 1'b1;
            default:   ptr_next = ptr_reg;
        endcase

        col_next = col_reg;
        row_next = row_reg;
        case (cw.cur_op)
            CUR_ADV:
            begin
                col_next = col_last ? '0 : col_reg + 1'b1;
            end
            CUR_LF:
            begin
                col_next = '0;
                row_next = row_last ? row_reg : row_reg + 1'b1;
            end
            CUR_HOME:
            begin
                col_next = '0;
                row_next = '0;
            end
            default:
            begin
                col_next = col_reg;
            end
        endcase

        scroll_next  = accept ? 1'b0 : (scroll_reg || cw.set_scroll);
        rd_flag_next = accept ? ((cmd.action == ACT_READ) && cmd_in_range) : rd_flag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg    <= ST_INIT;
            ptr_reg     <= '0;
            col_reg     <= '0;
            row_reg     <= '0;
            scroll_reg  <= 1'b0;
            rd_flag_reg <= 1'b0;
            color_reg   <= COLOR_RESET;
        end
        else
        begin
            step_reg    <= step_next;
            ptr_reg     <= ptr_next;
            col_reg     <= col_next;
            row_reg     <= row_next;
            scroll_reg  <= scroll_next;
            rd_flag_reg <= rd_flag_next;
            if (cfg_we)
            begin
                color_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= cmd;
        end
    end

    assign done              = cw.respond;
    assign result.cell_data  = rd_flag_reg ? rdata_reg : 16'h0000;
    assign result.cursor_row = 5'(row_reg);
    assign result.cursor_col = 7'(col_reg);
    assign result.scrolled   = scroll_reg;

`ifndef SYNTHESIS
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted command");

    a_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result beat outside a command");

    a_single_beat: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("more than one result beat for a command");

    a_scroll_cursor: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.scrolled) |-> (result.cursor_col == 7'd0
            && result.cursor_row == 5'(ROWS - 1)))
        else $error("cursor not at start of last row after scroll");
`endif

endmodule

// ----- tb/console_grid_checker.sv -----
// Checker for the text console cell writer: keeps its own copy of the cell grid,
// the cursor and the color register, predicts every result beat and compares it.
// Depends on tccw_pkg; instantiated beside the block by tb_text_console_cell_writer_top.
module console_grid_checker #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  tccw_pkg::in_item_t  cmd,
    input  logic                done,
    input  tccw_pkg::out_item_t result,
    input  logic                cfg_we,
    input  logic [7:0]          cfg_wdata,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output int                  scroll_count
);
    import tccw_pkg::*;

    logic [15:0] grid [ROWS*COLUMNS];
    int          cur_row;
    int          cur_col;
    logic [7:0]  color;
    out_item_t   expected_beats [$];
    int          n_fail;
    int          n_results;
    int          n_scrolls;

    function automatic void blank_grid();
        for (int i = 0; i < ROWS*COLUMNS; i++)
            grid[i] = BLANK_CELL;
    endfunction

    function automatic logic line_feed();
        cur_col = 0;
        if (cur_row + 1 < ROWS)
        begin
            cur_row++;
            return 1'b0;
        end
        for (int i = 0; i < (ROWS-1)*COLUMNS; i++)
            grid[i] = grid[i+COLUMNS];
        for (int i = (ROWS-1)*COLUMNS; i < ROWS*COLUMNS; i++)
            grid[i] = {color, SPACE_CODE};
        cur_row = ROWS - 1;
        return 1'b1;
    endfunction

    function automatic out_item_t predict_beat(input in_item_t c);
        out_item_t r;
        r = '0;
        case (c.action)
            ACT_PRINT:
            begin
                if (c.char_code == NEWLINE_CODE)
                    r.scrolled = line_feed();
                else
                begin
                    grid[cur_row*COLUMNS + cur_col] = {color, c.char_code};
                    cur_col++;
                    if (cur_col >= COLUMNS)
                        r.scrolled = line_feed();
                end
            end
            ACT_CLEAR:
            begin
                blank_grid();
                cur_row = 0;
                cur_col = 0;
            end
            ACT_READ:
            begin
                if (c.read_col < COLUMNS && c.read_row < ROWS)
                    r.cell_data = grid[c.read_row*COLUMNS + c.read_col];
            end
            default:
            begin
            end
        endcase
        r.cursor_row = cur_row[4:0];
        r.cursor_col = cur_col[6:0];
        return r;
    endfunction

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected 'h%0h, got 'h%0h", $time, name, want, got);
            n_fail++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : beat_watch
        out_item_t want;
        if (!rst_n)
        begin
            blank_grid();
            cur_row = 0;
            cur_col = 0;
            color = COLOR_RESET;
            expected_beats.delete();
            n_fail = 0;
            n_results = 0;
            n_scrolls = 0;
        end
        else
        begin
            if (cfg_we)
                color = cfg_wdata;
            if (done)
            begin
                n_results++;
                if (expected_beats.size() == 0)
                begin
                    $display("%0t: result beat with nothing expected, got 'h%0h",
                             $time, result);
                    n_fail++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    if (want.scrolled)
                        n_scrolls++;
                    check_field("cell_data", want.cell_data, result.cell_data);
                    check_field("cursor_row", want.cursor_row, result.cursor_row);
                    check_field("cursor_col", want.cursor_col, result.cursor_col);
                    check_field("scrolled", want.scrolled, result.scrolled);
                end
            end
            if (start && !busy)
                expected_beats.push_back(predict_beat(cmd));
        end
        fail_count   <= n_fail;
        pending      <= expected_beats.size();
        results_seen <= n_results;
        scroll_count <= n_scrolls;
    end

endmodule

// ----- tb/tb_text_console_cell_writer_top.sv -----
// Testbench top for the text console cell writer: clock, reset, command and
// color register stimulus, watchdog and verdict. Depends on tccw_pkg, the block
// and console_grid_checker, which predicts and compares the result beats.
module tb_text_console_cell_writer_top;
    import tccw_pkg::*;

    localparam logic [1:0] ACT_UNUSED  = 2'd3;
    localparam int         STALL_LIMIT = 20000;
    localparam int         ITEM_TARGET = 1650;
    localparam int         PHASES      = 6;

    logic       clk;
    logic       rst_n     = 1'b0;
    logic       start     = 1'b0;
    logic       busy;
    in_item_t   cmd       = '0;
    logic       done;
    out_item_t  result;
    logic       cfg_we    = 1'b0;
    logic [7:0] cfg_wdata = 8'd0;

    int fail_count;
    int pending;
    int results_seen;
    int scroll_count;
    int idle_pct     = 0;
    int sent         = 0;
    int quiet_cycles = 0;
    int color_writes = 0;

    text_console_cell_writer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .cmd       (cmd),
        .done      (done),
        .result    (result),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    console_grid_checker chk (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .fail_count   (fail_count),
        .pending      (pending),
        .results_seen (results_seen),
        .scroll_count (scroll_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("tb_text_console_cell_writer_top NOT OK");
            $finish;
        end
    end

    function automatic in_item_t make_cmd(input logic [1:0] act, input logic [7:0] ch,
                                          input logic [6:0] col, input logic [4:0] row);
        in_item_t c;
        c.action    = act;
        c.char_code = ch;
        c.read_col  = col;
        c.read_row  = row;
        return c;
    endfunction

    function automatic in_item_t noise_cmd(input logic [1:0] act, input logic [7:0] ch);
        return make_cmd(act, ch, 7'($urandom_range(127)), 5'($urandom_range(31)));
    endfunction

    task automatic send_cmd(input in_item_t item);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= item;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sent++;
    endtask

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_color(input logic [7:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        color_writes++;
    endtask

    task automatic random_segment();
        int pick;
        int count;
        pick = $urandom_range(99);
        if (pick < 2)
            send_cmd(noise_cmd(ACT_CLEAR, 8'($urandom_range(255))));
        else if (pick < 7)
            send_cmd(noise_cmd(ACT_UNUSED, 8'($urandom_range(255))));
        else if (pick < 32)
        begin
            count = $urandom_range(3, 1);
            repeat (count) send_cmd(noise_cmd(ACT_PRINT, NEWLINE_CODE));
        end
        else if (pick < 57)
        begin
            count = $urandom_range(4, 1);
            repeat (count)
            begin
                if ($urandom_range(99) < 15)
                    send_cmd(make_cmd(ACT_READ, 8'($urandom_range(255)),
                                      7'($urandom_range(127)), 5'($urandom_range(31))));
                else if ($urandom_range(1) == 0)
                    send_cmd(make_cmd(ACT_READ, 8'($urandom_range(255)),
                                      7'($urandom_range(79)), 5'($urandom_range(24, 20))));
                else
                    send_cmd(make_cmd(ACT_READ, 8'($urandom_range(255)),
                                      7'($urandom_range(79)), 5'($urandom_range(24))));
            end
        end
        else
        begin
            count = ($urandom_range(3) == 0) ? $urandom_range(120, 60) : $urandom_range(30, 1);
            repeat (count) send_cmd(noise_cmd(ACT_PRINT, 8'($urandom_range(255))));
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);
        while (busy)
            @(posedge clk);

        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd0, 5'd0));
        send_cmd(make_cmd(ACT_READ, 8'hFF, 7'd79, 5'd24));
        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd127, 5'd31));
        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd80, 5'd0));
        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd0, 5'd25));
        send_cmd(make_cmd(ACT_PRINT, 8'h00, 7'd127, 5'd31));
        send_cmd(make_cmd(ACT_PRINT, 8'hFF, 7'd0, 5'd0));
        send_cmd(make_cmd(ACT_PRINT, 8'h41, 7'd0, 5'd0));
        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd1, 5'd0));
        send_cmd(make_cmd(ACT_PRINT, NEWLINE_CODE, 7'd0, 5'd0));
        send_cmd(make_cmd(ACT_UNUSED, 8'hFF, 7'd127, 5'd31));
        send_cmd(make_cmd(ACT_UNUSED, 8'h00, 7'd0, 5'd0));
        send_cmd(make_cmd(ACT_PRINT, SPACE_CODE, 7'd0, 5'd0));
        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd0, 5'd1));
        send_cmd(make_cmd(ACT_CLEAR, 8'hFF, 7'd127, 5'd31));
        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd0, 5'd0));
        send_cmd(make_cmd(ACT_READ, 8'h00, 7'd1, 5'd0));

        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_quiet();
            case (phase)
                0: write_color(8'h00);
                1: write_color(8'hFF);
                default: write_color(8'($urandom_range(255)));
            endcase
            idle_pct = (phase % 3 == 1) ? 79 : ((phase % 3 == 2) ? 36 : 0);
            while (sent < ITEM_TARGET * (phase + 1) / PHASES)
                random_segment();
        end
        wait_quiet();

        $display("Sent %0d commands and checked %0d result beats, %0d of them with a scroll,",
                 sent, results_seen, scroll_count);
        $display("over %0d color settings and sender idle rates of 0, 36 and 79 percent.",
                 color_writes + 1);
        if (fail_count == 0 && pending == 0)
            $display("tb_text_console_cell_writer_top OK");
        else
            $display("tb_text_console_cell_writer_top NOT OK");
        $finish;
    end

endmodule
